// ===== rtl/lfu_cache_lru_tiebreak_unit_defines.svh =====
// ----------------------------------------------------------------------------
// LFU cache assertion macros
// Shared concurrent assertion forms, clocked on clk_i, off during reset.
// ----------------------------------------------------------------------------
`ifndef LFU_CACHE_LRU_TIEBREAK_UNIT_DEFINES_SVH
`define LFU_CACHE_LRU_TIEBREAK_UNIT_DEFINES_SVH

// same-cycle implication
`define LFU_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lfu cache assertion failed");

// next-cycle implication
`define LFU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lfu cache assertion failed");

`endif

// ===== rtl/lfu_lru_pkg.sv =====
// ----------------------------------------------------------------------------
// LFU cache package
// Sizes and word types of the LFU cache with LRU tie break.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lfu_lru_pkg;

  localparam int MaxEntries = 16;
  localparam int IdxW       = $clog2(MaxEntries);
  localparam int CntW       = $clog2(MaxEntries + 1);
  localparam int CapW       = 5;
  localparam int KeyW       = 32;
  localparam int DataW      = 32;
  localparam int UseW       = 32;

  localparam logic OpGet = 1'b0;
  localparam logic OpPut = 1'b1;

  typedef struct packed {
    logic                    op;
    logic signed [KeyW-1:0]  key;
    logic signed [DataW-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic                    hit;
    logic signed [DataW-1:0] read_value;
  } out_word_t;

endpackage

// ===== rtl/lfu_cache_lru_tiebreak_unit.sv =====
// ----------------------------------------------------------------------------
// LFU cache with LRU tie break
// Fully associative key-value store, least-frequently-used replacement.
// ----------------------------------------------------------------------------
// Input channel: in_valid_i / in_stall_o carry one word (op, key, value).
// Output channel: out_valid_o / out_stall_i carry one word (hit, read_value).
// A word moves at a clock edge where valid is high and stall is low.
// Each accepted word is scanned over all entries, one entry per cycle, by a
// single key/count/rank comparator in StScan, then StUpdate writes the entry
// store and StDone hands the result to the output register. No new word is
// taken until the block is back in StIdle; in_stall_o is high while a word
// is in work.
// The result sits in an output register; if the receiver stalls, the block
// holds the finished result and does not take the next word until the output
// register is free again.
// cfg_we_i / cfg_wdata_i write the capacity; the user must write it only while the block is idle (not enforced).
// Reset clears all valid marks, the occupancy and sets capacity to 16;
// no clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "lfu_cache_lru_tiebreak_unit_defines.svh"

module lfu_cache_lru_tiebreak_unit (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [lfu_lru_pkg::CapW-1:0] cfg_wdata_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  lfu_lru_pkg::in_word_t  in_data_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output lfu_lru_pkg::out_word_t out_data_o
);

  localparam int N    = lfu_lru_pkg::MaxEntries;
  localparam int IdxW = lfu_lru_pkg::IdxW;
  localparam int CntW = lfu_lru_pkg::CntW;
  localparam int CapW = lfu_lru_pkg::CapW;

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StUpdate,
    StDone
  } state_e;

  state_e state_q;

  logic [CapW-1:0] cap_q;
  logic [CntW-1:0] occ_q;
  logic [N-1:0]    valid_q;
  logic [N-1:0]    valid_upd;

  logic [lfu_lru_pkg::KeyW-1:0]  key_q  [N];
  logic [lfu_lru_pkg::DataW-1:0] data_q [N];
  logic [lfu_lru_pkg::UseW-1:0]  cnt_q  [N];
  logic [IdxW-1:0]               rank_q [N];
  logic [IdxW-1:0]               rank_d [N];

  lfu_lru_pkg::in_word_t  req_q;
  lfu_lru_pkg::out_word_t res_q;
  lfu_lru_pkg::out_word_t out_q;
  logic                   out_valid_q;

  logic [IdxW-1:0]              idx_q;
  logic                         found_q, free_q, vic_q;
  logic [IdxW-1:0]              found_idx_q, free_idx_q, vic_idx_q;
  logic [IdxW-1:0]              found_rank_q, vic_rank_q;
  logic [lfu_lru_pkg::UseW-1:0] vic_cnt_q;

  logic [CntW-1:0] cap_eff;
  logic            in_acc, out_free;
  logic            cur_valid, cur_match, cur_better;
  logic            do_touch, do_insert, do_evict, ins_ok;
  logic [IdxW-1:0] ins_idx;

  assign cap_eff = (cap_q > CapW'(N)) ? CntW'(N) : CntW'(cap_q);
  assign in_stall_o = (state_q != StIdle);
  assign in_acc = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o = out_q;

  // scan comparator
  assign cur_valid = valid_q[idx_q];
  assign cur_match = cur_valid && (key_q[idx_q] == req_q.key);
  assign cur_better = cur_valid && (!vic_q || (cnt_q[idx_q] < vic_cnt_q) ||
                      ((cnt_q[idx_q] == vic_cnt_q) && (rank_q[idx_q] > vic_rank_q)));

  // update decisions
  assign do_touch = found_q && ((req_q.op == lfu_lru_pkg::OpGet) || (cap_eff != '0));
  assign do_insert = (req_q.op == lfu_lru_pkg::OpPut) && !found_q && (cap_eff != '0);
  assign do_evict = do_insert && (occ_q >= cap_eff) && vic_q;
  assign ins_ok = do_evict || free_q;
  assign ins_idx = (do_evict && !(free_q && (free_idx_q < vic_idx_q))) ? vic_idx_q
                                                                       : free_idx_q;

  always_comb begin
    valid_upd = valid_q;
    if (do_evict) begin
      valid_upd[vic_idx_q] = 1'b0;
    end
    if (do_insert && ins_ok) begin
      valid_upd[ins_idx] = 1'b1;
    end
  end

  always_comb begin
    for (int j = 0; j < N; j++) begin
      rank_d[j] = rank_q[j];
      if (state_q == StUpdate) begin
        if (do_touch) begin
          if (IdxW'(j) == found_idx_q) begin
            rank_d[j] = '0;
          end else if (valid_q[j] && (rank_q[j] < found_rank_q)) begin
            rank_d[j] = rank_q[j] + 1'b1;
          end
        end else if (do_insert && ins_ok) begin
          if (IdxW'(j) == ins_idx) begin
            rank_d[j] = '0;
          end else if (valid_q[j] && !(do_evict && (IdxW'(j) == vic_idx_q))) begin
            if (do_evict && (rank_q[j] > vic_rank_q)) begin
              rank_d[j] = rank_q[j];
            end else begin
              rank_d[j] = rank_q[j] + 1'b1;
            end
          end
        end
      end
    end
  end

  // control, valid marks and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cap_q       <= CapW'(N);
      occ_q       <= '0;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
      found_q     <= 1'b0;
      free_q      <= 1'b0;
      vic_q       <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if ((state_q == StDone) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (in_acc) begin
            idx_q   <= '0;
            found_q <= 1'b0;
            free_q  <= 1'b0;
            vic_q   <= 1'b0;
            state_q <= StScan;
          end
        end
        StScan: begin
          if (cur_match && !found_q) begin
            found_q <= 1'b1;
          end
          if (!cur_valid && !free_q) begin
            free_q <= 1'b1;
          end
          if (cur_better) begin
            vic_q <= 1'b1;
          end
          if (idx_q == IdxW'(N - 1)) begin
            state_q <= StUpdate;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        StUpdate: begin
          valid_q <= valid_upd;
          if (do_insert && ins_ok && !do_evict) begin
            occ_q <= occ_q + 1'b1;
          end
          state_q <= StDone;
        end
        StDone: begin
          if (out_free) begin
            state_q <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  // payload: request, scan results, entry store
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      req_q <= in_data_i;
    end
    if (state_q == StScan) begin
      if (cur_match && !found_q) begin
        found_idx_q  <= idx_q;
        found_rank_q <= rank_q[idx_q];
      end
      if (!cur_valid && !free_q) begin
        free_idx_q <= idx_q;
      end
      if (cur_better) begin
        vic_idx_q  <= idx_q;
        vic_cnt_q  <= cnt_q[idx_q];
        vic_rank_q <= rank_q[idx_q];
      end
    end
    if (state_q == StUpdate) begin
      res_q <= '{hit: found_q,
                 read_value: (found_q && (req_q.op == lfu_lru_pkg::OpGet)) ?
                             data_q[found_idx_q] : '0};
      if (do_touch) begin
        if (cnt_q[found_idx_q] != '1) begin
          cnt_q[found_idx_q] <= cnt_q[found_idx_q] + 1'b1;
        end
        if (req_q.op == lfu_lru_pkg::OpPut) begin
          data_q[found_idx_q] <= req_q.value;
        end
      end else if (do_insert && ins_ok) begin
        key_q[ins_idx]  <= req_q.key;
        data_q[ins_idx] <= req_q.value;
        cnt_q[ins_idx]  <= lfu_lru_pkg::UseW'(1);
      end
    end
    if ((state_q == StDone) && out_free) begin
      out_q <= res_q;
    end
    rank_q <= rank_d;
  end

  `LFU_ASSERT_NEXT(a_accept_busy, in_acc, in_stall_o && (state_q == StScan))
  `LFU_ASSERT_IMPL(a_occ_count, 1'b1, $countones(valid_q) == occ_q)
  `LFU_ASSERT_IMPL(a_occ_max, 1'b1, occ_q <= CntW'(N))
  `LFU_ASSERT_NEXT(a_done_out, (state_q == StDone) && out_free, out_valid_o)

endmodule

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// LFU cache with LRU tie break: testbench
// Drives get/put words with random gaps against random result stalls, both off
// in every third random phase. Every accepted word runs through a behavioral
// cache model kept in the bench; the directed rows at the start carry
// hand-written results where they are obvious. The random part cycles the
// capacity through its extremes, including zero, saturation above the entry
// count and shrinking below the current fill.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  localparam int MaxEntries = lfu_lru_pkg::MaxEntries;
  localparam int CapW       = lfu_lru_pkg::CapW;
  localparam int KeyW       = lfu_lru_pkg::KeyW;
  localparam int DataW      = lfu_lru_pkg::DataW;
  localparam int UseW       = lfu_lru_pkg::UseW;

  localparam int CycleLimit = 400000;
  localparam int PoolSize   = 20;
  localparam int PhaseWords = 185;

  typedef struct packed {
    logic             op;
    logic [KeyW-1:0]  key;
    logic [DataW-1:0] value;
    logic             pinned;
    logic             exp_hit;
    logic [DataW-1:0] exp_rd;
  } dir_row_t;

  logic                   clk_i       = 1'b0;
  logic                   rst_ni      = 1'b0;
  logic                   cfg_we_i    = 1'b0;
  logic [CapW-1:0]        cfg_wdata_i = '0;
  logic                   in_valid_i  = 1'b0;
  logic                   in_stall_o;
  lfu_lru_pkg::in_word_t  in_data_i   = '0;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  lfu_lru_pkg::out_word_t out_data_o;

  // cache model state
  logic                slot_used [MaxEntries];
  logic [KeyW-1:0]     slot_key  [MaxEntries];
  logic [DataW-1:0]    slot_data [MaxEntries];
  logic [UseW-1:0]     slot_uses [MaxEntries];
  int unsigned         slot_age  [MaxEntries];
  int unsigned         slot_fill;
  logic [CapW-1:0]     cap_setting;

  lfu_lru_pkg::out_word_t pending_results [$];
  int unsigned         mismatch_count = 0;
  int unsigned         cycle_count    = 0;
  bit                  idle_on        = 1'b1;
  int unsigned         stall_hold     = 0;
  logic [KeyW-1:0]     key_pool [PoolSize];

  logic [CapW-1:0] cap_plan [8] = '{5'd31, 5'd3, 5'd0, 5'd1, 5'd17, 5'd8, 5'd16, 5'd2};

  dir_row_t dir_rows [25] = '{
    '{lfu_lru_pkg::OpGet, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000},
    '{lfu_lru_pkg::OpPut, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 1'b0, 32'h0000_0000},
    '{lfu_lru_pkg::OpGet, 32'h8000_0000, 32'h0000_0000, 1'b1, 1'b1, 32'h7FFF_FFFF},
    '{lfu_lru_pkg::OpPut, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 1'b0, 32'h0000_0000},
    '{lfu_lru_pkg::OpGet, 32'h7FFF_FFFF, 32'h0000_0000, 1'b1, 1'b1, 32'h8000_0000},
    '{lfu_lru_pkg::OpPut, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0000_0000},
    '{lfu_lru_pkg::OpGet, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 1'b1, 32'hFFFF_FFFF},
    '{lfu_lru_pkg::OpPut, 32'h8000_0000, 32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000},
    '{lfu_lru_pkg::OpGet, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'h0000_0000},
    '{lfu_lru_pkg::OpPut, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000},
    '{lfu_lru_pkg::OpPut, 32'h0000_0001, 32'h1000_0001, 1'b0, 1'b0, 32'h0000_0000},
    '{lfu_lru_pkg::OpPut, 32'h0000_0002, 32'h1000_0002, 1'b0, 1'b0, 32'h0000_0000},
    '{lfu_lru_pkg::OpPut, 32'h0000_0003, 32'h1000_0003, 1'b0, 1'b0, 32'h0000_0000},
    '{lfu_lru_pkg::OpPut, 32'h0000_0004, 32'h1000_0004, 1'b0, 1'b0, 32'h0000_0000},
    '{lfu_lru_pkg::OpPut, 32'h0000_0005, 32'h1000_0005, 1'b0, 1'b0, 32'h0000_0000},
    '{lfu_lru_pkg::OpPut, 32'h0000_0006, 32'h1000_0006, 1'b0, 1'b0, 32'h0000_0000},
    '{lfu_lru_pkg::OpPut, 32'h0000_0007, 32'h1000_0007, 1'b0, 1'b0, 32'h0000_0000},
    '{lfu_lru_pkg::OpPut, 32'h0000_0008, 32'h1000_0008, 1'b0, 1'b0, 32'h0000_0000},
    '{lfu_lru_pkg::OpPut, 32'h0000_0009, 32'h1000_0009, 1'b0, 1'b0, 32'h0000_0000},
    '{lfu_lru_pkg::OpPut, 32'h0000_000A, 32'h1000_000A, 1'b0, 1'b0, 32'h0000_0000},
    '{lfu_lru_pkg::OpPut, 32'h0000_000B, 32'h1000_000B, 1'b0, 1'b0, 32'h0000_0000},
    '{lfu_lru_pkg::OpPut, 32'h0000_000C, 32'h1000_000C, 1'b0, 1'b0, 32'h0000_0000},
    // store full: evicts the oldest of the count-one entries (key 0)
    '{lfu_lru_pkg::OpPut, 32'h0000_0100, 32'h5A5A_5A5A, 1'b0, 1'b0, 32'h0000_0000},
    '{lfu_lru_pkg::OpGet, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000},
    '{lfu_lru_pkg::OpGet, 32'h0000_0001, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000}
  };

  lfu_cache_lru_tiebreak_unit i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic void raise_use(input int s);
    if (slot_uses[s] != '1) slot_uses[s]++;
    for (int i = 0; i < MaxEntries; i++)
      if (slot_used[i] && i != s && slot_age[i] < slot_age[s]) slot_age[i]++;
    slot_age[s] = 0;
  endfunction

  function automatic lfu_lru_pkg::out_word_t cache_access(input lfu_lru_pkg::in_word_t w);
    lfu_lru_pkg::out_word_t res;
    int        hit_slot;
    int        victim;
    int        free_slot;
    int        eff_cap;
    hit_slot  = -1;
    victim    = -1;
    free_slot = -1;
    for (int i = 0; i < MaxEntries; i++)
      if (hit_slot < 0 && slot_used[i] && slot_key[i] == w.key) hit_slot = i;
    res.hit        = (hit_slot >= 0);
    res.read_value = '0;
    eff_cap = (cap_setting > MaxEntries) ? MaxEntries : int'(cap_setting);
    if (w.op == lfu_lru_pkg::OpGet) begin
      if (hit_slot >= 0) begin
        res.read_value = slot_data[hit_slot];
        raise_use(hit_slot);
      end
    end else if (eff_cap != 0) begin
      if (hit_slot >= 0) begin
        slot_data[hit_slot] = w.value;
        raise_use(hit_slot);
      end else begin
        if (slot_fill >= eff_cap) begin
          for (int i = 0; i < MaxEntries; i++)
            if (slot_used[i] && (victim < 0 || slot_uses[i] < slot_uses[victim] ||
                (slot_uses[i] == slot_uses[victim] && slot_age[i] > slot_age[victim])))
              victim = i;
          if (victim >= 0) begin
            slot_used[victim] = 1'b0;
            for (int i = 0; i < MaxEntries; i++)
              if (slot_used[i] && slot_age[i] > slot_age[victim]) slot_age[i]--;
            slot_fill--;
          end
        end
        for (int i = 0; i < MaxEntries; i++)
          if (free_slot < 0 && !slot_used[i]) free_slot = i;
        if (free_slot >= 0) begin
          for (int i = 0; i < MaxEntries; i++)
            if (slot_used[i]) slot_age[i]++;
          slot_used[free_slot] = 1'b1;
          slot_key[free_slot]  = w.key;
          slot_data[free_slot] = w.value;
          slot_uses[free_slot] = 1;
          slot_age[free_slot]  = 0;
          slot_fill++;
        end
      end
    end
    return res;
  endfunction

  task automatic send_word(input lfu_lru_pkg::in_word_t w, input logic pinned,
                           input lfu_lru_pkg::out_word_t pinned_res);
    lfu_lru_pkg::out_word_t model_res;
    int        gap;
    gap = idle_on ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    model_res = cache_access(w);
    pending_results.push_back(pinned ? pinned_res : model_res);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_capacity(input logic [CapW-1:0] cap);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= cap;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cap_setting = cap;
  endtask

  // result side: stall for a drawn number of cycles once a word is offered
  always @(posedge clk_i) begin : result_check
    lfu_lru_pkg::out_word_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected word, expected none, got hit %0b value %h", $time,
                   out_data_o.hit, out_data_o.read_value);
        end else begin
          want = pending_results.pop_front();
          if (out_data_o.hit !== want.hit) begin
            mismatch_count++;
            $display("%0t: hit expected %0b got %0b", $time, want.hit, out_data_o.hit);
          end
          if (out_data_o.read_value !== want.read_value) begin
            mismatch_count++;
            $display("%0t: read_value expected %h got %h", $time, want.read_value,
                     out_data_o.read_value);
          end
        end
        stall_hold = idle_on ? $urandom_range(0, 7) : 0;
      end else if (out_valid_o && stall_hold > 0) begin
        stall_hold--;
      end
      out_stall_i <= (stall_hold > 0);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("[lfu_cache_lru_tiebreak_unit] ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    lfu_lru_pkg::in_word_t  w;
    lfu_lru_pkg::out_word_t pinned_res;
    for (int i = 0; i < MaxEntries; i++) begin
      slot_used[i] = 1'b0;
      slot_key[i]  = '0;
      slot_data[i] = '0;
      slot_uses[i] = '0;
      slot_age[i]  = 0;
    end
    slot_fill   = 0;
    cap_setting = 5'd16;
    for (int i = 0; i < PoolSize; i++) key_pool[i] = $urandom;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_capacity(5'd16);

    foreach (dir_rows[r]) begin
      w.op               = dir_rows[r].op;
      w.key              = dir_rows[r].key;
      w.value            = dir_rows[r].value;
      pinned_res.hit        = dir_rows[r].exp_hit;
      pinned_res.read_value = dir_rows[r].exp_rd;
      send_word(w, dir_rows[r].pinned, pinned_res);
    end
    drain();

    foreach (cap_plan[ph]) begin
      write_capacity(cap_plan[ph]);
      idle_on = (ph % 3 != 1);
      for (int i = 0; i < 4; i++) key_pool[$urandom_range(0, PoolSize - 1)] = $urandom;
      for (int n = 0; n < PhaseWords; n++) begin
        w.op    = ($urandom_range(0, 99) < 45) ? lfu_lru_pkg::OpPut : lfu_lru_pkg::OpGet;
        w.key   = ($urandom_range(0, 7) != 0) ? key_pool[$urandom_range(0, PoolSize - 1)]
                                              : $urandom;
        w.value = $urandom;
        send_word(w, 1'b0, '0);
      end
      drain();
    end

    repeat (25) @(posedge clk_i);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("[lfu_cache_lru_tiebreak_unit] OK");
    end else begin
      $display("[lfu_cache_lru_tiebreak_unit] ERROR");
    end
    $finish;
  end

endmodule
